// File: rtl/ialu_pkg.sv
// Package for the integer ALU: command codes, payload word types, divider step.
// No dependencies.
package ialu_pkg;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_ADDU  = 4'd1,
        CMD_AND   = 4'd2,
        CMD_OR    = 4'd3,
        CMD_XOR   = 4'd4,
        CMD_SUB   = 4'd5,
        CMD_SUBU  = 4'd6,
        CMD_SUBC  = 4'd7,
        CMD_SLL   = 4'd8,
        CMD_SRA   = 4'd9,
        CMD_SRL   = 4'd10,
        CMD_MULT  = 4'd11,
        CMD_MULTU = 4'd12,
        CMD_DIV   = 4'd13,
        CMD_DIVU  = 4'd14,
        CMD_NONE  = 4'd15
    } cmd_t;

    localparam int DATA_W     = 32;
    localparam int BITS_STAGE = 4;
    localparam int DIV_STAGES = DATA_W / BITS_STAGE;

    typedef struct packed {
        logic [3:0]        command;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic [DATA_W-1:0] high_word;
        logic [DATA_W-1:0] low_word;
        logic              overflow_flag;
    } out_word_t;

    // one restoring step: shift in next dividend bit, try subtract
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
    } div_state_t;

    function automatic div_state_t div_step(div_state_t s, logic [DATA_W-1:0] d);
        logic [DATA_W:0] trial;
        div_state_t      o;
        trial = {s.rem, s.quo[DATA_W-1]};
        o.quo = {s.quo[DATA_W-2:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            trial    = trial - {1'b0, d};
            o.quo[0] = 1'b1;
        end
        o.rem = trial[DATA_W-1:0];
        return o;
    endfunction

endpackage

// File: rtl/ialu_mul.sv
// Pipelined 33x33 signed multiplier as four 17x17-ish partial products.
// Depends on ialu_pkg. Latency must match ialu_div; advances only when en is high.
module ialu_mul (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       sgn,
    input  logic [ialu_pkg::DATA_W-1:0] a,
    input  logic [ialu_pkg::DATA_W-1:0] b,
    output logic [2*ialu_pkg::DATA_W-1:0] prod
);
    import ialu_pkg::*;

    localparam int H = DATA_W / 2;
    localparam int LAT = DIV_STAGES + 2;

    logic signed [H:0]          ah, bh;
    logic        [H-1:0]        al, bl;
    logic signed [2*H+1:0]      hh_reg;
    logic signed [H+1:0]        alx, blx;
    logic signed [2*H+3:0]      hl_reg, lh_reg;
    logic        [2*H-1:0]      ll_reg;
    logic        [2*DATA_W-1:0] sum_reg;
    logic        [2*DATA_W-1:0] dly_reg [LAT-2];
    logic        [2*DATA_W-1:0] sum_next;

    assign ah  = {sgn & a[DATA_W-1], a[DATA_W-1:H]};
    assign bh  = {sgn & b[DATA_W-1], b[DATA_W-1:H]};
    assign al  = a[H-1:0];
    assign bl  = b[H-1:0];
    assign alx = {2'b00, al};
    assign blx = {2'b00, bl};

    always_comb
    begin
        sum_next = 64'(signed'(hh_reg)) <<< (2 * H);
        sum_next = sum_next + (64'(signed'(hl_reg)) <<< H);
        sum_next = sum_next + (64'(signed'(lh_reg)) <<< H);
        sum_next = sum_next + 64'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg  <= (2*H+2)'(ah) * (2*H+2)'(bh);
            hl_reg  <= (2*H+4)'(ah) * (2*H+4)'(blx);
            lh_reg  <= (2*H+4)'(alx) * (2*H+4)'(bh);
            ll_reg  <= (2*H)'(al) * (2*H)'(bl);
            sum_reg <= sum_next;
            dly_reg[0] <= sum_reg;
            for (int i = 1; i < LAT - 2; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    assign prod = dly_reg[LAT-3];
endmodule

// File: rtl/ialu_div.sv
// Pipelined restoring divider, four quotient bits per stage, sign fixup around it.
// Depends on ialu_pkg. Advances only when en is high.
module ialu_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       sgn,
    input  logic [ialu_pkg::DATA_W-1:0] a,
    input  logic [ialu_pkg::DATA_W-1:0] b,
    output logic [ialu_pkg::DATA_W-1:0] quo,
    output logic [ialu_pkg::DATA_W-1:0] rem
);
    import ialu_pkg::*;

    div_state_t        st_reg  [DIV_STAGES+1];
    logic [DATA_W-1:0] d_reg   [DIV_STAGES+1];
    logic              qn_reg  [DIV_STAGES+1];
    logic              rn_reg  [DIV_STAGES+1];
    logic              z_reg   [DIV_STAGES+1];
    div_state_t        stg_next [DIV_STAGES];
    logic [DATA_W-1:0] ma, mb, q_reg, r_reg;
    logic              an, bn;

    assign an = sgn & a[DATA_W-1];
    assign bn = sgn & b[DATA_W-1];
    assign ma = an ? (~a + 1'b1) : a;
    assign mb = bn ? (~b + 1'b1) : b;

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            stg_next[s] = st_reg[s];
            for (int k = 0; k < BITS_STAGE; k++)
                stg_next[s] = div_step(stg_next[s], d_reg[s]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= '{rem: '0, quo: ma};
            d_reg[0]  <= mb;
            qn_reg[0] <= an ^ bn;
            rn_reg[0] <= an;
            z_reg[0]  <= (b == '0);
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                st_reg[s+1] <= stg_next[s];
                d_reg[s+1]  <= d_reg[s];
                qn_reg[s+1] <= qn_reg[s];
                rn_reg[s+1] <= rn_reg[s];
                z_reg[s+1]  <= z_reg[s];
            end
            q_reg <= z_reg[DIV_STAGES] ? '0 : (qn_reg[DIV_STAGES] ?
                     (~st_reg[DIV_STAGES].quo + 1'b1) : st_reg[DIV_STAGES].quo);
            r_reg <= z_reg[DIV_STAGES] ? '0 : (rn_reg[DIV_STAGES] ?
                     (~st_reg[DIV_STAGES].rem + 1'b1) : st_reg[DIV_STAGES].rem);
        end
    end

    assign quo = q_reg;
    assign rem = r_reg;
endmodule

// File: rtl/integer_alu_mul_div.sv
// Integer ALU with multiply and divide.
// Channels: in (command, operand_a, operand_b) and out (result_value,
// high_word, low_word, overflow_flag), each a packed word with valid and
// stall; a word moves on a clock edge with valid high and stall low.
// Every input word gives exactly one output word, in order.
// All commands share the depth of the divider path: 8 divider stages of four
// quotient bits, one operand/sign setup stage, one sign fixup stage and the
// output register. Throughput is one word per cycle unless the output stalls.
// The whole pipeline, simple ops included, advances together; when the
// receiver stalls with a valid word at the output, every stage holds and in_stall
// is raised, so nothing is lost or repeated. Empty slots in the pipeline do not
// fill while the output is stalled.
// Reset clears all valid bits; the block is ready in the cycle after reset.
// Depends on ialu_pkg, ialu_mul, ialu_div.
module integer_alu_mul_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ialu_pkg::in_word_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ialu_pkg::out_word_t out_data
);
    import ialu_pkg::*;

    localparam int LAT = DIV_STAGES + 2;

    logic              v_reg   [LAT];
    logic [3:0]        cmd_reg [LAT];
    logic [DATA_W-1:0] res_reg [LAT];
    logic              ovf_reg [LAT];
    logic              en;
    logic [3:0]        cmd;
    logic [DATA_W-1:0] a, b, res_next, sum, dif;
    logic [4:0]        sh;
    logic              ovf_next;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0] quo, rem;
    logic [3:0]        cl;
    out_word_t         out_next, out_reg;
    logic              ov_reg;

    assign en       = !(ov_reg && out_stall);
    assign in_stall = !en;
    assign cmd = in_data.command;
    assign a   = in_data.operand_a;
    assign b   = in_data.operand_b;
    assign sh  = a[4:0];
    assign sum = a + b;
    assign dif = a - b;

    always_comb
    begin
        res_next = '0;
        ovf_next = 1'b0;
        case (cmd)
            CMD_ADD:
            begin
                if (~(a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ sum[DATA_W-1]))
                    ovf_next = 1'b1;
                else
                    res_next = sum;
            end
            CMD_ADDU: res_next = sum;
            CMD_AND:  res_next = a & b;
            CMD_OR:   res_next = a | b;
            CMD_XOR:  res_next = a ^ b;
            CMD_SUB, CMD_SUBU: res_next = dif;
            CMD_SUBC: res_next = (a < b) ? '0 : dif;
            CMD_SLL:  res_next = b << sh;
            CMD_SRA:  res_next = DATA_W'($signed(b) >>> sh);
            CMD_SRL:  res_next = b >> sh;
            default:  res_next = '0;
        endcase
    end

    ialu_mul u_mul (
        .clk  (clk),
        .en   (en),
        .sgn  (cmd == CMD_MULT),
        .a    (a),
        .b    (b),
        .prod (prod)
    );

    ialu_div u_div (
        .clk (clk),
        .en  (en),
        .sgn (cmd == CMD_DIV),
        .a   (a),
        .b   (b),
        .quo (quo),
        .rem (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                v_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                v_reg[i] <= v_reg[i-1];
            ov_reg <= v_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg[0] <= cmd;
            res_reg[0] <= res_next;
            ovf_reg[0] <= ovf_next;
            for (int i = 1; i < LAT; i++)
            begin
                cmd_reg[i] <= cmd_reg[i-1];
                res_reg[i] <= res_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
            out_reg <= out_next;
        end
    end

    assign cl = cmd_reg[LAT-1];

    always_comb
    begin
        out_next               = '0;
        out_next.result_value  = res_reg[LAT-1];
        out_next.overflow_flag = ovf_reg[LAT-1];
        case (cl)
            CMD_MULT, CMD_MULTU:
            begin
                out_next.high_word = prod[2*DATA_W-1:DATA_W];
                out_next.low_word  = prod[DATA_W-1:0];
            end
            CMD_DIV, CMD_DIVU:
            begin
                out_next.high_word = rem;
                out_next.low_word  = quo;
            end
            default:
            begin
                out_next.high_word = '0;
                out_next.low_word  = '0;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;
endmodule

// File: bench/tb.sv
// Testbench for integer_alu_mul_div: directed and random commands, checked
// against a built-in predictor of each output word. Depends on ialu_pkg, integer_alu_mul_div.
`timescale 1ns / 100ps

module tb;
    import ialu_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 30;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_data;

    out_word_t expected_words[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        gaps_on = 1'b1;

    integer_alu_mul_div u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #5 clk = ~clk;

    function automatic out_word_t alu_predict(in_word_t w);
        out_word_t         r;
        logic [31:0]       a, b, s, qa, qb, q, rm;
        logic [63:0]       p;
        logic [4:0]        sh;
        a = w.operand_a;
        b = w.operand_b;
        sh = a[4:0];
        r = '0;
        case (cmd_t'(w.command))
            CMD_ADD:
            begin
                s = a + b;
                if (a[31] == b[31] && s[31] != a[31])
                    r.overflow_flag = 1'b1;
                else
                    r.result_value = s;
            end
            CMD_ADDU:  r.result_value = a + b;
            CMD_AND:   r.result_value = a & b;
            CMD_OR:    r.result_value = a | b;
            CMD_XOR:   r.result_value = a ^ b;
            CMD_SUB, CMD_SUBU: r.result_value = a - b;
            CMD_SUBC:  r.result_value = (a < b) ? 32'd0 : a - b;
            CMD_SLL:   r.result_value = b << sh;
            CMD_SRA:   r.result_value = $signed(b) >>> sh;
            CMD_SRL:   r.result_value = b >> sh;
            CMD_MULT:
            begin
                p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                {r.high_word, r.low_word} = p;
            end
            CMD_MULTU:
            begin
                p = {32'd0, a} * {32'd0, b};
                {r.high_word, r.low_word} = p;
            end
            CMD_DIV:
                if (b != 0)
                begin
                    qa = a[31] ? -a : a;
                    qb = b[31] ? -b : b;
                    q = qa / qb;
                    rm = qa % qb;
                    r.low_word  = (a[31] ^ b[31]) ? -q : q;
                    r.high_word = a[31] ? -rm : rm;
                end
            CMD_DIVU:
                if (b != 0)
                begin
                    r.low_word  = a / b;
                    r.high_word = a % b;
                end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(cmd_t c, logic [31:0] a, logic [31:0] b);
        in_word_t w;
        w.command = c;
        w.operand_a = a;
        w.operand_b = b;
        while (gaps_on && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_words.push_back(alu_predict(w));
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000 | $urandom_range(3);
            3: return 32'h7FFF_FFFF - $urandom_range(3);
            4: return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_words.size() != 0);
    endtask

    task automatic test_directed();
        send_word(CMD_ADD, 32'h7FFF_FFFF, 32'd1);
        send_word(CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(CMD_ADD, 32'd5, 32'hFFFF_FFFD);
        send_word(CMD_ADDU, 32'hFFFF_FFFF, 32'd1);
        send_word(CMD_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_word(CMD_OR, 32'h0, 32'h1234_5678);
        send_word(CMD_XOR, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
        send_word(CMD_SUB, 32'd0, 32'd1);
        send_word(CMD_SUBU, 32'h8000_0000, 32'd1);
        send_word(CMD_SUBC, 32'd3, 32'd4);
        send_word(CMD_SUBC, 32'd4, 32'd4);
        send_word(CMD_SLL, 32'hFFFF_FFE1, 32'h8000_0001);
        send_word(CMD_SRA, 32'd31, 32'h8000_0000);
        send_word(CMD_SRA, 32'h20, 32'h8000_0000);
        send_word(CMD_SRL, 32'd31, 32'hFFFF_FFFF);
        send_word(CMD_MULT, 32'h8000_0000, 32'h8000_0000);
        send_word(CMD_MULT, 32'hFFFF_FFFF, 32'd7);
        send_word(CMD_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_DIV, 32'hFFFF_FFF9, 32'd2);
        send_word(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(CMD_DIV, 32'd5, 32'd0);
        send_word(CMD_DIVU, 32'hFFFF_FFFF, 32'd0);
        send_word(CMD_DIVU, 32'hFFFF_FFFF, 32'd10);
        send_word(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_word(cmd_t'($urandom_range(15)), rand_operand(), rand_operand());
    endtask

    task automatic test_back_to_back(int count);
        gaps_on = 1'b0;
        test_random(count);
        gaps_on = 1'b1;
    endtask

    always @(negedge clk)
        out_stall <= gaps_on ? ($urandom_range(99) < 28) : 1'b0;

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected output word");
                error_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (out_data.result_value !== e.result_value)
                begin
                    $error("result_value exp %h got %h", e.result_value, out_data.result_value);
                    error_count++;
                end
                if (out_data.high_word !== e.high_word)
                begin
                    $error("high_word exp %h got %h", e.high_word, out_data.high_word);
                    error_count++;
                end
                if (out_data.low_word !== e.low_word)
                begin
                    $error("low_word exp %h got %h", e.low_word, out_data.low_word);
                    error_count++;
                end
                if (out_data.overflow_flag !== e.overflow_flag)
                begin
                    $error("overflow_flag exp %b got %b", e.overflow_flag,
                           out_data.overflow_flag);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        wait_drained();
        test_random(900);
        test_back_to_back(300);
        test_random(600);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

// File: integer_alu_mul_div.f
rtl/ialu_pkg.sv
rtl/ialu_mul.sv
rtl/ialu_div.sv
rtl/integer_alu_mul_div.sv
bench/tb.sv
